[rtl/assert_macros.svh]
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/piv_pkg.sv]
`timescale 1ns / 1ps
package piv_pkg;
	typedef enum logic [2:0] {
		KIND_NONE     = 3'd0,
		KIND_BOX      = 3'd1,
		KIND_PLANE    = 3'd2,
		KIND_SPHERE   = 3'd3,
		KIND_CYLINDER = 3'd4,
		KIND_CONE     = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		REG_KIND   = 3'd0,
		REG_ORIGIN = 3'd1,
		REG_AXIS   = 3'd2,
		REG_OUTER  = 3'd3,
		REG_INNER  = 3'd4,
		REG_INV    = 3'd5
	} reg_idx_t;

	localparam int INV_W     = 48;
	localparam int INV_FRAC  = 40;
	localparam int DIST_FRAC = 32;
	localparam int DQ_W      = 33;

	typedef struct packed {
		logic en_a;
		logic en_b;
	} sq_en_t;
endpackage

[rtl/piv_wide_sq.sv]
`timescale 1ns / 1ps
module piv_wide_sq #(
	parameter int W = 54
) (
	input  logic             clk,
	input  piv_pkg::sq_en_t  en,
	input  logic [W-1:0]     a,
	output logic [2*W-1:0]   sq
);
	localparam int L  = W / 2;
	localparam int H  = W - L;
	localparam int W2 = 2 * W;

	logic [H-1:0]     ah;
	logic [L-1:0]     al;
	logic [2*H-1:0]   hh_s1;
	logic [H+L-1:0]   hl_s1;
	logic [2*L-1:0]   ll_s1;
	logic [W2-1:0]    sq_s2;

	assign ah = a[W-1:L];
	assign al = a[L-1:0];

	// square split into high, cross and low partial products
	always_ff @(posedge clk) begin
		if (en.en_a) begin
			hh_s1 <= ah * ah;
			hl_s1 <= ah * al;
			ll_s1 <= al * al;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_b) begin
			sq_s2 <= (W2'(hh_s1) << (2 * L)) + (W2'(hl_s1) << (L + 1)) + W2'(ll_s1);
		end
	end

	assign sq = sq_s2;
endmodule

[rtl/point_in_volume_test.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// point_in_volume_test: one point per request on s_axis, one inside flag per request on m_axis,
// in order. A point enters every cycle while s_axis_tready is high; the answer leaves through the
// ten-stage pipeline (difference, axis products, dot sum, reciprocal partial products,
// axial range check, radial products, radial components, squares, sums, final compare).
// s_axis_tready drops only while a finished answer waits on m_axis; bubbles close up.
// Configuration is taken from cfg_we/cfg_index/cfg_data and must only change while idle.
module point_in_volume_test #(
	parameter int COORD_WIDTH   = 21,
	parameter int FRACTION_BITS = 8,
	localparam int CFG_W   = (3 * COORD_WIDTH > piv_pkg::INV_W) ? 3 * COORD_WIDTH : piv_pkg::INV_W,
	localparam int TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // point_x, point_y, point_z
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [7:0]         m_axis_tdata   // inside_res
);
	import piv_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int F     = FRACTION_BITS;
	localparam int XW    = CW + 1;
	localparam int AXW   = CW + XW;
	localparam int DOTW  = AXW + 2;
	localparam int DU    = DOTW - 1;
	localparam int DL    = DU / 2;
	localparam int DH    = DU - DL;
	localparam int IL    = INV_W / 2;
	localparam int IH    = INV_W - IL;
	localparam int PW    = DU + INV_W;
	localparam int THR_SH = 2 * F + INV_FRAC;
	localparam int DQ_SH = 2 * F + 8;
	localparam int ADW   = CW + DQ_W + 1;
	localparam int RW    = CW + 2;
	localparam int RSW   = 2 * RW + 2;
	localparam int MW    = CW + DQ_W;
	localparam int CMPW  = RSW + 2 * DIST_FRAC;
	localparam int PNW   = 2 * CW;
	localparam int PLW   = 2 * CW + F + 2;
	localparam int SQW   = 2 * CW;
	localparam int NST   = 10;

	// configuration
	kind_t                 kind_q;
	logic [3*CW-1:0]       origin_q;
	logic [3*CW-1:0]       axis_q;
	logic signed [CW-1:0]  outer_q;
	logic [CW-2:0]         inner_q;
	logic [INV_W-1:0]      inv_q;
	logic [CW-1:0]         rom_q;
	logic [SQW-1:0]        rom_sq_q;
	logic [SQW-1:0]        ri_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_NONE;
			origin_q <= '0;
			axis_q   <= '0;
			outer_q  <= '0;
			inner_q  <= '0;
			inv_q    <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KIND:   kind_q   <= kind_t'(cfg_data[2:0]);
				REG_ORIGIN: origin_q <= cfg_data[3*CW-1:0];
				REG_AXIS:   axis_q   <= cfg_data[3*CW-1:0];
				REG_OUTER:  outer_q  <= cfg_data[CW-1:0];
				REG_INNER:  inner_q  <= cfg_data[CW-2:0];
				REG_INV:    inv_q    <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	// radius magnitudes and squares are registered after the configuration registers, the outer square after rom_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_q    <= '0;
			rom_sq_q <= '0;
			ri_sq_q  <= '0;
		end else begin
			rom_q    <= outer_q[CW-1] ? CW'(-outer_q) : CW'(outer_q);
			rom_sq_q <= rom_q * rom_q;
			ri_sq_q  <= SQW'(inner_q) * SQW'(inner_q);
		end
	end

	logic signed [CW-1:0] pt  [3];
	logic signed [CW-1:0] org [3];
	logic signed [CW-1:0] axs [3];
	logic                 box_c;

	always_comb begin
		box_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			pt[i]  = s_axis_tdata[i*CW +: CW];
			org[i] = origin_q[i*CW +: CW];
			axs[i] = axis_q[i*CW +: CW];
			if (pt[i] < org[i] || pt[i] > axs[i])
				box_c = 1'b0;
		end
	end

	// pipeline flow control
	logic [NST:1]   stage_vld_q;
	logic [NST+1:1] en;

	always_comb begin
		en[NST+1] = m_axis_tready;
		for (int k = NST; k >= 1; k--)
			en[k] = !stage_vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en[1])
				stage_vld_q[1] <= s_axis_tvalid;
			for (int k = 2; k <= NST; k++)
				if (en[k])
					stage_vld_q[k] <= stage_vld_q[k-1];
		end
	end

	assign s_axis_tready = en[1];

	// stage 1: offsets, plane products, box test
	logic signed [XW-1:0]  x_s1 [3];
	logic signed [PNW-1:0] pn_s1 [3];
	logic                  box_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				x_s1[i]  <= XW'(pt[i]) - XW'(org[i]);
				pn_s1[i] <= pt[i] * axs[i];
			end
			box_s1 <= box_c;
		end
	end

	// stage 2: axis products, plane compare, box or plane select
	logic signed [AXW-1:0] ax_s2 [3];
	logic signed [XW-1:0]  x_s2 [3];
	logic                  simple_s2;
	logic signed [PLW-1:0] pn_sum;
	logic signed [PLW-1:0] plane_thr;

	assign pn_sum    = PLW'(pn_s1[0]) + PLW'(pn_s1[1]) + PLW'(pn_s1[2]);
	assign plane_thr = -(PLW'(outer_q) <<< F);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				ax_s2[i] <= axs[i] * x_s1[i];
				x_s2[i]  <= x_s1[i];
			end
			if (kind_q == KIND_BOX)
				simple_s2 <= box_s1;
			else if (kind_q == KIND_PLANE)
				simple_s2 <= (pn_sum >= plane_thr);
			else
				simple_s2 <= 1'b0;
		end
	end

	// stage 3: axial dot product
	logic signed [DOTW-1:0] dot_s3;
	logic signed [XW-1:0]   x_s3 [3];
	logic                   simple_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			dot_s3    <= DOTW'(ax_s2[0]) + DOTW'(ax_s2[1]) + DOTW'(ax_s2[2]);
			x_s3      <= x_s2;
			simple_s3 <= simple_s2;
		end
	end

	// stage 4: partial products of dot and reciprocal
	logic [DL+IL-1:0]     pp_ll_s4;
	logic [DL+IH-1:0]     pp_lh_s4;
	logic [DH+IL-1:0]     pp_hl_s4;
	logic [DH+IH-1:0]     pp_hh_s4;
	logic                 neg_s4;
	logic                 pos_s4;
	logic signed [XW-1:0] x_s4 [3];
	logic                 simple_s4;
	logic [DU-1:0]        dot_u;

	assign dot_u = dot_s3[DU-1:0];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			pp_ll_s4  <= dot_u[DL-1:0] * inv_q[IL-1:0];
			pp_lh_s4  <= dot_u[DL-1:0] * inv_q[INV_W-1:IL];
			pp_hl_s4  <= dot_u[DU-1:DL] * inv_q[IL-1:0];
			pp_hh_s4  <= dot_u[DU-1:DL] * inv_q[INV_W-1:IL];
			neg_s4    <= dot_s3[DOTW-1];
			pos_s4    <= !dot_s3[DOTW-1] && (dot_s3 != '0);
			x_s4      <= x_s3;
			simple_s4 <= simple_s3;
		end
	end

	// stage 5: axial range check and distance
	logic [PW-1:0]        prod;
	logic                 over_c;
	logic                 axial_c;
	logic                 inv_nz;
	logic [DQ_W-1:0]      dq_s5;
	logic                 rej_s5;
	logic signed [XW-1:0] x_s5 [3];
	logic                 simple_s5;

	assign prod = PW'(pp_ll_s4) + (PW'(pp_lh_s4) << IL) + (PW'(pp_hl_s4) << DL)
		+ (PW'(pp_hh_s4) << (DL + IL));
	assign over_c  = prod > (PW'(1) << THR_SH);
	assign axial_c = (kind_q == KIND_CYLINDER) || (kind_q == KIND_CONE);
	assign inv_nz  = |inv_q;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			rej_s5    <= axial_c && inv_nz && (neg_s4 || (pos_s4 && over_c));
			dq_s5     <= (axial_c && inv_nz && pos_s4) ? prod[DQ_SH +: DQ_W] : '0;
			x_s5      <= x_s4;
			simple_s5 <= simple_s4;
		end
	end

	// stage 6: axis times distance, radius times distance
	logic signed [DQ_W:0]  dq_sgn;
	logic signed [ADW-1:0] ad_s6 [3];
	logic signed [XW-1:0]  x_s6 [3];
	logic [MW-1:0]         mo_s6;
	logic [MW-1:0]         mi_s6;
	logic                  rej_s6;
	logic                  simple_s6;

	assign dq_sgn = {1'b0, dq_s5};

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int i = 0; i < 3; i++)
				ad_s6[i] <= axs[i] * dq_sgn;
			mo_s6     <= MW'(rom_q) * MW'(dq_s5);
			mi_s6     <= MW'(inner_q) * MW'(dq_s5);
			x_s6      <= x_s5;
			rej_s6    <= rej_s5;
			simple_s6 <= simple_s5;
		end
	end

	// stage 7: radial components
	logic signed [RW-1:0] r_s7 [3];
	logic                 rej_s7;
	logic                 simple_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int i = 0; i < 3; i++)
				r_s7[i] <= RW'(x_s6[i]) - RW'(ad_s6[i] >>> DIST_FRAC);
			rej_s7    <= rej_s6;
			simple_s7 <= simple_s6;
		end
	end

	// cone limits squared over stages 7 and 8
	logic [2*MW-1:0] mo2;
	logic [2*MW-1:0] mi2;
	sq_en_t          sq_en;

	assign sq_en.en_a = en[7];
	assign sq_en.en_b = en[8];

	piv_wide_sq #(.W(MW)) u_sq_outer (
		.clk (clk),
		.en  (sq_en),
		.a   (mo_s6),
		.sq  (mo2)
	);

	piv_wide_sq #(.W(MW)) u_sq_inner (
		.clk (clk),
		.en  (sq_en),
		.a   (mi_s6),
		.sq  (mi2)
	);

	// stage 8: squares
	logic [2*RW-1:0] rsq_s8 [3];
	logic            rej_s8;
	logic            simple_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			for (int i = 0; i < 3; i++)
				rsq_s8[i] <= r_s7[i] * r_s7[i];
			rej_s8    <= rej_s7;
			simple_s8 <= simple_s7;
		end
	end

	// stage 9: squared radial distance
	logic [RSW-1:0]  rs_s9;
	logic [2*MW-1:0] mo2_s9;
	logic [2*MW-1:0] mi2_s9;
	logic            rej_s9;
	logic            simple_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			rs_s9     <= RSW'(rsq_s8[0]) + RSW'(rsq_s8[1]) + RSW'(rsq_s8[2]);
			mo2_s9    <= mo2;
			mi2_s9    <= mi2;
			rej_s9    <= rej_s8;
			simple_s9 <= simple_s8;
		end
	end

	// stage 10: final compare, output register
	logic [CMPW-1:0] rs_wide;
	logic            shell_ok;
	logic            cone_ok;
	logic            inside_c;
	logic            inside_s10;

	assign rs_wide  = CMPW'(rs_s9) << (2 * DIST_FRAC);
	assign shell_ok = (rs_s9 <= RSW'(rom_sq_q)) && (rs_s9 >= RSW'(ri_sq_q));
	assign cone_ok  = (rs_wide <= CMPW'(mo2_s9)) && (rs_wide >= CMPW'(mi2_s9));

	always_comb begin
		unique case (kind_q)
			KIND_BOX, KIND_PLANE:        inside_c = simple_s9;
			KIND_SPHERE, KIND_CYLINDER:  inside_c = !rej_s9 && shell_ok;
			KIND_CONE:                   inside_c = !rej_s9 && cone_ok;
			default:                     inside_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[10])
			inside_s10 <= inside_c;
	end

	assign m_axis_tvalid = stage_vld_q[NST];
	assign m_axis_tdata  = {7'b0, inside_s10};

	`ASSERT_IMPL(a_stall_only_on_hold, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without a held result")
	`ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, stage_vld_q[1], "accepted request missing in stage 1")
	`ASSERT_IMPL(a_dq_range, stage_vld_q[5] && !rej_s5, dq_s5 <= (DQ_W'(1) << DIST_FRAC), "axial distance above one")
	`ASSERT_IMPL(a_sphere_no_axial, stage_vld_q[5] && kind_q == KIND_SPHERE, dq_s5 == '0 && !rej_s5, "sphere took the axial path")
endmodule

[tb/point_in_volume_test_tb.sv]
`timescale 1ns / 1ps
module point_in_volume_test_tb;
	import piv_pkg::*;

	localparam int CW = 21;
	localparam int FB = 8;
	localparam int CFG_W = 63;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		bit signed [CW-1:0] x;
		bit signed [CW-1:0] y;
		bit signed [CW-1:0] z;
	} point_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata;  // point_x, point_y, point_z, zero pad
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [7:0] m_axis_tdata;   // inside_res, zero pad

	point_in_volume_test dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// shadow copy of the volume registers
	kind_t vol_kind;
	bit [3*CW-1:0] vol_origin;
	bit [3*CW-1:0] vol_axis;
	bit [CW-1:0] vol_outer;
	bit [CW-2:0] vol_inner;
	bit [INV_W-1:0] vol_inv;

	point_t pending_points[$];
	bit inside_expected[$];
	point_t driven_point;
	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint coord_of(bit [3*CW-1:0] v, int i);
		bit signed [CW-1:0] c;
		c = v[i*CW +: CW];
		return c;
	endfunction

	function automatic bit [3*CW-1:0] pack_xyz(longint x, longint y, longint z);
		bit [CW-1:0] px, py, pz;
		px = x[CW-1:0];
		py = y[CW-1:0];
		pz = z[CW-1:0];
		return {pz, py, px};
	endfunction

	function automatic bit axial_inside(longint pt[3], bit cone);
		longint xv[3], av[3];
		longint dot, r, rs, ro;
		bit [127:0] prod, lhs, hi_lim, lo_lim, tmp;
		bit [63:0] dq, rom, ri;
		dot = 0;
		rs = 0;
		dq = 0;
		for (int i = 0; i < 3; i++) begin
			xv[i] = pt[i] - coord_of(vol_origin, i);
			av[i] = coord_of(vol_axis, i);
			dot += av[i] * xv[i];
		end
		if (vol_inv != 0 && dot < 0)
			return 1'b0;
		if (vol_inv != 0 && dot > 0) begin
			prod = {64'b0, 64'(dot)} * {80'b0, vol_inv};
			if (prod > (128'd1 << (2 * FB + INV_FRAC)))
				return 1'b0;
			dq = prod[2*FB+INV_FRAC-DIST_FRAC +: 64];
		end
		for (int i = 0; i < 3; i++) begin
			r = xv[i] - ((av[i] * longint'(dq)) >>> DIST_FRAC);
			rs += r * r;
		end
		ro = longint'(signed'(vol_outer));
		rom = (ro < 0) ? -ro : ro;
		ri = vol_inner;
		if (!cone)
			return (rs <= rom * rom) && (rs >= ri * ri);
		lhs = {64'(rs), 64'b0};
		tmp = {64'b0, rom * dq};
		hi_lim = tmp * tmp;
		tmp = {64'b0, ri * dq};
		lo_lim = tmp * tmp;
		return (lhs <= hi_lim) && (lo_lim <= lhs);
	endfunction

	function automatic bit predict_inside(point_t p);
		longint pt[3];
		longint dot, rs, r, ro, ri;
		bit res;
		pt[0] = p.x;
		pt[1] = p.y;
		pt[2] = p.z;
		res = 1'b0;
		ro = longint'(signed'(vol_outer));
		ri = vol_inner;
		case (vol_kind)
			KIND_BOX: begin
				res = 1'b1;
				for (int i = 0; i < 3; i++)
					if (pt[i] < coord_of(vol_origin, i) || pt[i] > coord_of(vol_axis, i))
						res = 1'b0;
			end
			KIND_PLANE: begin
				dot = 0;
				for (int i = 0; i < 3; i++)
					dot += pt[i] * coord_of(vol_axis, i);
				res = dot >= -ro * (longint'(1) << FB);
			end
			KIND_SPHERE: begin
				rs = 0;
				for (int i = 0; i < 3; i++) begin
					r = pt[i] - coord_of(vol_origin, i);
					rs += r * r;
				end
				res = (rs <= ro * ro) && (rs >= ri * ri);
			end
			KIND_CYLINDER: res = axial_inside(pt, 1'b0);
			KIND_CONE: res = axial_inside(pt, 1'b1);
			default: res = 1'b0;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				inside_expected.push_back(predict_inside(driven_point));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					driven_point = pending_points.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {1'b0, pack_xyz(driven_point.x, driven_point.y,
						driven_point.z)};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// answer side and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (inside_expected.size() == 0) begin
					report_mismatch("answer with no request outstanding");
				end else if (m_axis_tdata !== {7'b0, inside_expected.pop_front()}) begin
					report_mismatch($sformatf("inside flag: got %h", m_axis_tdata));
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (pending_points.size() == 0 && inside_expected.size() == 0 && !s_axis_tvalid))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, bit [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KIND: vol_kind = kind_t'(data[2:0]);
			REG_ORIGIN: vol_origin = data;
			REG_AXIS: vol_axis = data;
			REG_OUTER: vol_outer = data[CW-1:0];
			REG_INNER: vol_inner = data[CW-2:0];
			REG_INV: vol_inv = data[INV_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_volume(kind_t k, bit [CFG_W-1:0] org, bit [CFG_W-1:0] ax,
		longint outer, longint inner, bit [CFG_W-1:0] inv);
		write_reg(REG_KIND, CFG_W'(k));
		write_reg(REG_ORIGIN, org);
		write_reg(REG_AXIS, ax);
		write_reg(REG_OUTER, CFG_W'(outer) & ((63'd1 << CW) - 1));
		write_reg(REG_INNER, CFG_W'(inner));
		write_reg(REG_INV, inv);
	endtask

	task automatic drain();
		while (pending_points.size() > 0 || s_axis_tvalid || inside_expected.size() > 0)
			@(posedge clk);
		repeat (14) @(posedge clk);
	endtask

	function automatic longint srand(longint span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic point_t make_point(longint x, longint y, longint z);
		point_t p;
		p.x = x[CW-1:0];
		p.y = y[CW-1:0];
		p.z = z[CW-1:0];
		return p;
	endfunction

	// points that land around the configured volume, with full-range noise mixed in
	function automatic point_t near_point();
		longint c[3];
		longint span, k;
		if ($urandom_range(99) < 20)
			return make_point($urandom, $urandom, $urandom);
		span = longint'(signed'(vol_outer));
		if (span < 0)
			span = -span;
		span = span + span / 2 + 16;
		k = longint'($urandom_range(0, 40)) - 4;
		for (int i = 0; i < 3; i++) begin
			case (vol_kind)
				KIND_BOX: c[i] = coord_of(vol_origin, i) + srand(64) + longint'($urandom_range(0,
					(coord_of(vol_axis, i) > coord_of(vol_origin, i)) ?
					coord_of(vol_axis, i) - coord_of(vol_origin, i) + 64 : 64));
				KIND_PLANE: c[i] = srand(8192);
				KIND_SPHERE: c[i] = coord_of(vol_origin, i) + srand(span);
				KIND_CYLINDER, KIND_CONE: c[i] = coord_of(vol_origin, i) +
					coord_of(vol_axis, i) * k / 32 + srand(span);
				default: c[i] = srand(1 << 20);
			endcase
		end
		return make_point(c[0], c[1], c[2]);
	endfunction

	task automatic random_volume(int phase);
		longint a[3], o[3], len_sq, outer, inner;
		bit [CFG_W-1:0] inv;
		kind_t k;
		k = kind_t'(1 + phase % 5);
		for (int i = 0; i < 3; i++) begin
			o[i] = srand(100000);
			a[i] = srand(2000);
		end
		a[0] = a[0] + 300;
		len_sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		inv = (64'd1 << (INV_FRAC + 2 * FB)) / len_sq;
		if ($urandom_range(9) == 0)
			inv = 0;
		outer = $urandom_range(0, 4000);
		inner = ($urandom_range(9) == 0) ? outer + 10 : $urandom_range(0, outer);
		if ($urandom_range(4) == 0)
			outer = -outer;
		case (k)
			KIND_BOX: begin
				for (int i = 0; i < 3; i++)
					a[i] = o[i] + srand(200) + 1500;
			end
			KIND_PLANE: begin
				for (int i = 0; i < 3; i++)
					a[i] = srand(256);
				outer = srand(8192);
			end
			KIND_CONE: begin
				outer = $urandom_range(0, 600);
				inner = $urandom_range(0, outer);
			end
			default: ;
		endcase
		write_volume(k, pack_xyz(o[0], o[1], o[2]), pack_xyz(a[0], a[1], a[2]),
			outer, inner, inv);
	endtask

	task automatic push_corner_points();
		pending_points.push_back(make_point(1 << 20, 1 << 20, 1 << 20));
		pending_points.push_back(make_point((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1));
		pending_points.push_back(make_point(0, 0, 0));
		pending_points.push_back(make_point(256, -256, 512));
	endtask

	initial begin
		bit [CFG_W-1:0] org, ax;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		vol_kind = KIND_NONE;
		vol_origin = '0;
		vol_axis = '0;
		vol_outer = '0;
		vol_inner = '0;
		vol_inv = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset state answers outside, then each kind with fixed volumes
		push_corner_points();
		drain();
		org = pack_xyz(-512, -512, -512);
		ax = pack_xyz(512, 512, 512);
		write_volume(KIND_BOX, org, ax, 0, 0, 0);
		pending_points.push_back(make_point(-512, 512, 0));
		pending_points.push_back(make_point(-513, 0, 0));
		push_corner_points();
		drain();
		write_volume(KIND_PLANE, 0, pack_xyz(0, 256, 0), 256, 0, 0);
		pending_points.push_back(make_point(0, -256, 0));
		pending_points.push_back(make_point(0, -257, 0));
		push_corner_points();
		drain();
		// shell from 1.0 to 2.0 around the origin, outer boundary exactly, inner just below
		write_volume(KIND_SPHERE, 0, 0, -512, 256, 0);
		pending_points.push_back(make_point(512, 0, 0));
		pending_points.push_back(make_point(0, 255, 0));
		push_corner_points();
		drain();
		// unit axis along z, inverse length squared exactly one
		write_volume(KIND_CYLINDER, 0, pack_xyz(0, 0, 256), 512, 0, 64'd1 << INV_FRAC);
		pending_points.push_back(make_point(0, 0, 257));
		pending_points.push_back(make_point(512, 0, 256));
		push_corner_points();
		drain();
		write_volume(KIND_CONE, 0, pack_xyz(0, 0, 256), 256, 0, 64'd1 << INV_FRAC);
		pending_points.push_back(make_point(256, 0, 256));
		pending_points.push_back(make_point(128, 0, 128));
		pending_points.push_back(make_point(0, 0, -1));
		push_corner_points();
		drain();
		// unused kinds and ignored indexes
		write_reg(REG_KIND, 63'd6);
		write_reg(reg_idx_t'(3'd6), '1);
		write_reg(reg_idx_t'(3'd7), '1);
		push_corner_points();
		drain();

		for (int phase = 0; phase < 18; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 47; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 47; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			if (phase == 15) begin
				// register extremes: full-range corners and the largest radii
				write_volume(KIND_CONE, '1, {1'b0, 62'h0}, -(1 << 20), (1 << 20) - 1, '1);
			end else if (phase == 16) begin
				write_volume(kind_t'($urandom_range(0, 7)),
					{$urandom, $urandom}, {$urandom, $urandom},
					$urandom, $urandom, {$urandom, $urandom});
			end else if (phase == 17) begin
				write_volume(KIND_SPHERE, '0, '1, (1 << 20) - 1, 0, '1);
			end else begin
				random_volume(phase);
			end
			for (int n = 0; n < 45; n++)
				pending_points.push_back(near_point());
			if (phase == 6) begin
				// hold off until every answer is back, then continue
				while (pending_points.size() > 0 || s_axis_tvalid || inside_expected.size() > 0)
					@(posedge clk);
			end
			for (int n = 0; n < 45; n++)
				pending_points.push_back(near_point());
			drain();
		end

		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/piv_pkg.sv
rtl/piv_wide_sq.sv
rtl/point_in_volume_test.sv
tb/point_in_volume_test_tb.sv
